// File: design/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants for the P6 stream decoder: parser phases,
// result kinds, the job record passed from parser to divider, character codes.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned ACC_W      = 17;
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [ACC_W-1:0]  ACC_SAT    = 17'd65536;
  localparam logic [QUOT_W-1:0] SAMPLE_MAX = 8'd255;

  // character codes
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // parser phases; gap, comment and number phases come in groups of three, one per header field
  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1,
    PH_GAP0, PH_GAP1, PH_GAP2,
    PH_COM0, PH_COM1, PH_COM2,
    PH_NUM0, PH_NUM1, PH_NUM2,
    PH_MAXCOM, PH_HIGH, PH_LOW, PH_DONE, PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    KIND_WIDTH, KIND_HEIGHT, KIND_MAXVAL, KIND_SAMPLE, KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_DIV, BK_DONE
  } back_e;

  // one queued job: a finished header result, an error, or a raw sample with its divisor
  typedef struct packed {
    kind_e                kind;
    logic [VALUE_W-1:0]   value;
    logic                 last;
    logic [VALUE_W-1:0]   divisor;
  } job_t;

  // header field index of a gap, comment or number phase
  function automatic logic [1:0] field_of(input phase_e ph);
    logic [1:0] f;
    unique case (ph)
      PH_GAP1, PH_COM1, PH_NUM1: f = 2'd1;
      PH_GAP2, PH_COM2, PH_NUM2: f = 2'd2;
      default:                   f = 2'd0;
    endcase
    return f;
  endfunction

  function automatic phase_e gap_of(input logic [1:0] f);
    phase_e ph;
    unique case (f)
      2'd1:    ph = PH_GAP1;
      2'd2:    ph = PH_GAP2;
      default: ph = PH_GAP0;
    endcase
    return ph;
  endfunction

  function automatic phase_e com_of(input logic [1:0] f);
    phase_e ph;
    unique case (f)
      2'd1:    ph = PH_COM1;
      2'd2:    ph = PH_COM2;
      default: ph = PH_COM0;
    endcase
    return ph;
  endfunction

  function automatic phase_e num_of(input logic [1:0] f);
    phase_e ph;
    unique case (f)
      2'd1:    ph = PH_NUM1;
      2'd2:    ph = PH_NUM2;
      default: ph = PH_NUM0;
    endcase
    return ph;
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

endpackage

// File: design/ppm_front.sv
// ----------------------------------------------------------------------------
// ppm_front
// Header parser and raster byte collector. Takes one byte per transaction,
// emits header results, errors and raw samples as jobs into the queue.
// ----------------------------------------------------------------------------
module ppm_front
  import ppm_pkg::*;
#(
  parameter int unsigned SIDE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              start_i,
  output logic              push_o,
  output job_t              job_o
);

  localparam int unsigned W3_W   = SIDE_BITS + 2;
  localparam int unsigned LEFT_W = 2 * SIDE_BITS + 2;

  phase_e               phase_q, phase_d, cur_phase;
  logic [ACC_W-1:0]     acc_q, acc_d, cur_acc;
  logic [SIDE_BITS-1:0] width_q, width_d, cur_width;
  logic [W3_W-1:0]      width3_q, width3_d, cur_width3;
  logic [SIDE_BITS-1:0] height_q, height_d, cur_height;
  logic [VALUE_W-1:0]   maxval_q, maxval_d, cur_maxval;
  logic [BYTE_W-1:0]    held_q, held_d, cur_held;
  logic [LEFT_W-1:0]    left_q, left_d, cur_left;

  logic [1:0]           fld;
  logic [3:0]           digit;
  logic [ACC_W+2:0]     acc_mul;
  logic                 b_space, b_digit, b_hash, b_eol, b_wide;
  logic                 emit;
  job_t                 job;

  // a start byte restarts from the reset state before being used
  always_comb begin
    if (start_i) begin
      cur_phase  = PH_MAGIC0;
      cur_acc    = '0;
      cur_width  = '0;
      cur_width3 = '0;
      cur_height = '0;
      cur_maxval = VALUE_W'(SAMPLE_MAX);
      cur_held   = '0;
      cur_left   = '0;
    end else begin
      cur_phase  = phase_q;
      cur_acc    = acc_q;
      cur_width  = width_q;
      cur_width3 = width3_q;
      cur_height = height_q;
      cur_maxval = maxval_q;
      cur_held   = held_q;
      cur_left   = left_q;
    end
  end

  // byte classes
  assign b_space = is_space(byte_i);
  assign b_digit = is_digit(byte_i);
  assign b_hash  = (byte_i == CHAR_HASH);
  assign b_eol   = (byte_i == CHAR_LF) || (byte_i == CHAR_CR);
  assign digit   = 4'(byte_i - CHAR_ZERO);
  assign fld     = field_of(cur_phase);
  assign b_wide  = (cur_maxval[VALUE_W-1:BYTE_W] != '0);

  // accumulator times ten plus digit, as shifts and adds
  assign acc_mul = {cur_acc, 3'b000} + {2'b00, cur_acc, 1'b0} + (ACC_W+3)'(digit);

  // parser next state
  always_comb begin
    phase_d  = cur_phase;
    acc_d    = cur_acc;
    width_d  = cur_width;
    width3_d = cur_width3;
    height_d = cur_height;
    maxval_d = cur_maxval;
    held_d   = cur_held;
    left_d   = cur_left;
    emit     = 1'b0;
    job      = '{kind: KIND_ERROR, value: '0, last: 1'b0, divisor: cur_maxval};

    unique case (cur_phase)
      PH_MAGIC0: phase_d = PH_MAGIC1;
      PH_MAGIC1: phase_d = PH_GAP0;
      PH_GAP0, PH_GAP1, PH_GAP2: begin
        if (b_space) begin
          phase_d = cur_phase;
        end else if (b_hash) begin
          phase_d = com_of(fld);
        end else if (b_digit) begin
          acc_d   = ACC_W'(digit);
          phase_d = num_of(fld);
        end else begin
          phase_d = PH_ERROR;
          emit    = 1'b1;
        end
      end
      PH_COM0, PH_COM1, PH_COM2: begin
        if (b_eol) begin
          phase_d = gap_of(fld);
        end
      end
      PH_NUM0, PH_NUM1, PH_NUM2: begin
        if (b_digit) begin
          acc_d = (acc_mul > (ACC_W+3)'(ACC_SAT)) ? ACC_SAT : acc_mul[ACC_W-1:0];
        end else if (b_space || b_hash) begin
          // number ends here
          acc_d = '0;
          emit  = 1'b1;
          if (fld != 2'd2) begin
            if (cur_acc[ACC_W-1:SIDE_BITS] != '0) begin
              phase_d = PH_ERROR;
            end else begin
              job.kind  = kind_e'({1'b0, fld});
              job.value = cur_acc[VALUE_W-1:0];
              if (fld == 2'd0) begin
                width_d  = cur_acc[SIDE_BITS-1:0];
                width3_d = {1'b0, cur_acc[SIDE_BITS-1:0], 1'b0}
                         + {2'b00, cur_acc[SIDE_BITS-1:0]};
                phase_d  = b_hash ? PH_COM1 : PH_GAP1;
              end else begin
                height_d = cur_acc[SIDE_BITS-1:0];
                phase_d  = b_hash ? PH_COM2 : PH_GAP2;
              end
            end
          end else if ((cur_acc == '0) || cur_acc[ACC_W-1]) begin
            phase_d = PH_ERROR;
          end else begin
            job.kind  = KIND_MAXVAL;
            job.value = cur_acc[VALUE_W-1:0];
            maxval_d  = cur_acc[VALUE_W-1:0];
            left_d    = LEFT_W'(cur_width3 * cur_height);
            if (b_hash) begin
              phase_d = PH_MAXCOM;
            end else if ((cur_width == '0) || (cur_height == '0)) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = (cur_acc[VALUE_W-1:BYTE_W] != '0) ? PH_HIGH : PH_LOW;
            end
          end
        end else begin
          phase_d = PH_ERROR;
          emit    = 1'b1;
        end
      end
      PH_MAXCOM: begin
        if (b_eol) begin
          if (cur_left == '0) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = b_wide ? PH_HIGH : PH_LOW;
          end
        end
      end
      PH_HIGH: begin
        held_d  = byte_i;
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        emit      = 1'b1;
        job.kind  = KIND_SAMPLE;
        job.value = b_wide ? {cur_held, byte_i} : {{(VALUE_W-BYTE_W){1'b0}}, byte_i};
        job.last  = (cur_left == LEFT_W'(1));
        left_d    = cur_left - LEFT_W'(1);
        if (job.last) begin
          phase_d = PH_DONE;
        end else begin
          phase_d = b_wide ? PH_HIGH : PH_LOW;
        end
      end
      PH_DONE, PH_ERROR: phase_d = cur_phase;
      default:           phase_d = cur_phase;
    endcase
  end

  assign push_o = accept_i && emit;
  assign job_o  = job;

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC0;
      acc_q    <= '0;
      width_q  <= '0;
      width3_q <= '0;
      height_q <= '0;
      maxval_q <= VALUE_W'(SAMPLE_MAX);
      held_q   <= '0;
      left_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      width_q  <= width_d;
      width3_q <= width3_d;
      height_q <= height_d;
      maxval_q <= maxval_d;
      held_q   <= held_d;
      left_q   <= left_d;
    end
  end

endmodule

// File: design/ppm_fifo.sv
// ----------------------------------------------------------------------------
// ppm_fifo
// Short job queue between parser and divider so each side stalls on its own.
// ----------------------------------------------------------------------------
module ppm_fifo
  import ppm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  job_t             slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("job popped from empty queue");

endmodule

// File: design/ppm_back.sv
// ----------------------------------------------------------------------------
// ppm_back
// Carries out queued jobs: header results and errors pass straight to the output
// register, samples go through a radix-2 divider for floor(255*s/maxval).
// ----------------------------------------------------------------------------
module ppm_back
  import ppm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               job_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [VALUE_W-1:0] m_tdata_o,
  output logic [2:0]         m_tuser_o,
  output logic               m_tlast_o
);

  localparam int unsigned PROD_W = VALUE_W + QUOT_W;
  localparam int unsigned STEP_W = $clog2(QUOT_W);

  back_e               state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [VALUE_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0]   lo_q, lo_d;
  logic [QUOT_W-1:0]   quo_q, quo_d;
  logic [VALUE_W-1:0]  div_q, div_d;
  logic                sat_q, sat_d;
  logic                last_q, last_d;

  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic                out_last_q;

  logic                out_free, load_out;
  kind_e               load_kind;
  logic [VALUE_W-1:0]  load_value;
  logic                load_last;
  logic [PROD_W-1:0]   scaled;
  logic [VALUE_W:0]    trial;
  logic                ge;

  assign out_free = !out_valid_q || m_tready_i;

  // 255*s as a shift and subtract
  assign scaled = {job_i.value, {QUOT_W{1'b0}}} - PROD_W'(job_i.value);

  // one quotient bit per step
  assign trial = {rem_q, lo_q[QUOT_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  // job sequencer
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    rem_d      = rem_q;
    lo_d       = lo_q;
    quo_d      = quo_q;
    div_d      = div_q;
    sat_d      = sat_q;
    last_d     = last_q;
    pop_o      = 1'b0;
    load_out   = 1'b0;
    load_kind  = job_i.kind;
    load_value = job_i.value;
    load_last  = job_i.last;

    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (job_i.kind == KIND_SAMPLE) begin
            pop_o   = 1'b1;
            rem_d   = scaled[PROD_W-1:QUOT_W];
            lo_d    = scaled[QUOT_W-1:0];
            div_d   = job_i.divisor;
            last_d  = job_i.last;
            quo_d   = '0;
            sat_d   = 1'b0;
            step_d  = '0;
            state_d = BK_DIV;
          end else if (out_free) begin
            pop_o    = 1'b1;
            load_out = 1'b1;
          end
        end
      end
      BK_DIV: begin
        if (step_q == '0) begin
          sat_d = (rem_q >= div_q);
        end
        rem_d  = ge ? VALUE_W'(trial - {1'b0, div_q}) : trial[VALUE_W-1:0];
        lo_d   = {lo_q[QUOT_W-2:0], 1'b0};
        quo_d  = {quo_q[QUOT_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(QUOT_W - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_kind  = KIND_SAMPLE;
          load_value = VALUE_W'(sat_q ? SAMPLE_MAX : quo_q);
          load_last  = last_q;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    sat_q  <= sat_d;
    last_q <= last_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q  <= load_kind;
      out_value_q <= load_value;
      out_last_q  <= load_last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_value_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  // scaled samples stay within eight bits
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_SAMPLE)) |-> (out_value_q[VALUE_W-1:QUOT_W] == '0))
    else $error("scaled sample above 255");

  // only samples carry the last mark
  a_last_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_kind_q == KIND_SAMPLE))
    else $error("last mark on a header result");

  // the divider runs exactly its quotient steps before finishing
  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_DIV) && (step_q != STEP_W'(QUOT_W - 1))) |=> (state_q == BK_DIV))
    else $error("divider left early");

endmodule

// File: design/ppm_p6_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder_unit
// Binary PPM (P6) stream decoder: parses the header, reports width, height
// and maxval, and rescales each raster sample to 8 bits.
//
//   channel   dir  tdata                   tuser              tlast
//   s_axis    in   [7:0] byte_value        [0] start_of_file  -
//   m_axis    out  [15:0] value            [2:0] kind         last_sample
//
// Input bytes are taken one per cycle while the job queue has room. For
// each sample the back end loads 255*s, runs eight radix-2 quotient steps,
// then moves the result into the output register once that is free.
// Reset clears the parser, queue, divider state and output valid at once.
// A stalled output holds its result; the divider finishes its sample and waits,
// the queue keeps filling until it is full, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder_unit
  import ppm_pkg::*;
#(
  parameter int unsigned SIDE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [BYTE_W-1:0]   s_axis_tdata_i,   // [7:0] byte_value
  input  logic                s_axis_tuser_i,   // [0] start_of_file
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [VALUE_W-1:0]  m_axis_tdata_o,   // [15:0] value
  output logic [2:0]          m_axis_tuser_o,   // [2:0] kind
  output logic                m_axis_tlast_o    // last_sample
);

  logic accept, push, full, pop, empty;
  job_t push_job, head_job;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  // header parser and sample collector
  ppm_front #(
    .SIDE_BITS (SIDE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .start_i  (s_axis_tuser_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  // job queue
  ppm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty)
  );

  // divider and output stage
  ppm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
